// ===== rtl/core/dese_pkg.sv =====
// dese_pkg: shared types and constants for the debug expression stack evaluator
// depends on nothing; used by every module in rtl/core
package dese_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int IDX_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W = 64;

	localparam logic [4:0] OP_PUSH     = 5'd0;
	localparam logic [4:0] OP_PUSH_REG = 5'd1;
	localparam logic [4:0] OP_ADD      = 5'd2;
	localparam logic [4:0] OP_SUB      = 5'd3;
	localparam logic [4:0] OP_MUL      = 5'd4;
	localparam logic [4:0] OP_DIV      = 5'd5;
	localparam logic [4:0] OP_MOD      = 5'd6;
	localparam logic [4:0] OP_AND      = 5'd7;
	localparam logic [4:0] OP_OR       = 5'd8;
	localparam logic [4:0] OP_NOT      = 5'd9;
	localparam logic [4:0] OP_XOR      = 5'd10;
	localparam logic [4:0] OP_ABS      = 5'd11;
	localparam logic [4:0] OP_SHL      = 5'd12;
	localparam logic [4:0] OP_SHR      = 5'd13;
	localparam logic [4:0] OP_SAR      = 5'd14;
	localparam logic [4:0] OP_GE       = 5'd15;
	localparam logic [4:0] OP_LE       = 5'd16;
	localparam logic [4:0] OP_GT       = 5'd17;
	localparam logic [4:0] OP_LT       = 5'd18;
	localparam logic [4:0] OP_EQ       = 5'd19;
	localparam logic [4:0] OP_NE       = 5'd20;
	localparam logic [4:0] OP_ADDCONST = 5'd21;
	localparam logic [4:0] OP_DEREF    = 5'd22;
	localparam logic [4:0] OP_PICK     = 5'd23;
	localparam logic [4:0] OP_DROP     = 5'd24;
	localparam logic [4:0] OP_ILLEGAL  = 5'd25;
	localparam logic [4:0] OP_CLEAR    = 5'd26;

	typedef struct packed {
		logic [4:0]        operation;
		logic [DATA_W-1:0] value;
		logic [7:0]        immediate;
		logic              read_ok;
	} item_t;

	typedef struct packed {
		logic [DATA_W-1:0] top_value;
		logic [6:0]        stack_depth;
		logic              error_flag;
	} result_t;

	typedef enum logic [1:0] {
		CM_HOLD  = 2'd0,
		CM_DOWN  = 2'd1,
		CM_UP    = 2'd2,
		CM_WRTOP = 2'd3
	} cell_mode_t;

	// one command broadcast to every cell of the stack row
	typedef struct packed {
		cell_mode_t        mode;
		logic [IDX_W-1:0]  idx;
		logic              wr0;
		logic [DATA_W-1:0] wval;
	} cell_ctrl_t;

endpackage

// ===== rtl/core/dese_cell.sv =====
// dese_cell: one stack entry of the cell row, position counted from the top
// depends on dese_pkg
module dese_cell (
	input  logic                          clk,
	input  logic [dese_pkg::IDX_W-1:0]    pos,
	input  dese_pkg::cell_ctrl_t          ctrl,
	input  logic [dese_pkg::DATA_W-1:0]   above,
	input  logic [dese_pkg::DATA_W-1:0]   below,
	output logic [dese_pkg::DATA_W-1:0]   data
);

	logic [dese_pkg::DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (ctrl.mode)
			dese_pkg::CM_DOWN: begin
				data_q <= (pos == '0) ? ctrl.wval : below;
			end
			dese_pkg::CM_UP: begin
				if (pos >= ctrl.idx)
					data_q <= above;
				else if (pos == '0 && ctrl.wr0)
					data_q <= ctrl.wval;
			end
			dese_pkg::CM_WRTOP: begin
				if (pos == '0)
					data_q <= ctrl.wval;
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule

// ===== rtl/core/dese_divider.sv =====
// dese_divider: 64-bit unsigned restoring divider, one quotient bit per cycle
// depends on dese_pkg
module dese_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dese_pkg::DATA_W-1:0]   dividend,
	input  logic [dese_pkg::DATA_W-1:0]   divisor,
	output logic                          done,
	output logic [dese_pkg::DATA_W-1:0]   quotient,
	output logic [dese_pkg::DATA_W-1:0]   remainder
);

	localparam int STEP_W = $clog2(dese_pkg::DATA_W);

	logic                        busy_q;
	logic                        done_q;
	logic [STEP_W-1:0]           step_q;
	logic [dese_pkg::DATA_W-1:0] rem_q;
	logic [dese_pkg::DATA_W-1:0] quo_q;
	logic [dese_pkg::DATA_W-1:0] div_q;
	logic [dese_pkg::DATA_W:0]   trial;
	logic [dese_pkg::DATA_W:0]   diff;

	assign trial = {rem_q, quo_q[dese_pkg::DATA_W-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(dese_pkg::DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!diff[dese_pkg::DATA_W]) begin
				rem_q <= diff[dese_pkg::DATA_W-1:0];
				quo_q <= {quo_q[dese_pkg::DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[dese_pkg::DATA_W-1:0];
				quo_q <= {quo_q[dese_pkg::DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/core/dwarf_expression_stack_evaluator.sv =====
// timing: an item passes S_EXEC, then S_MUL, S_DIV or the pick states where needed, then S_REPORT,
// which loads the output register; for pick the row rotates to the entry and back
// throughput: one item at a time; the next item is taken only after S_REPORT has loaded its
// result into the output register; a deep pick is the worst case, and a stalled result holds
// the next item's result in S_REPORT until it is taken
// reset: depth and error flag clear, stack entries stay undefined until pushed
module dwarf_expression_stack_evaluator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  dese_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_stall,
	output dese_pkg::result_t   result
);

	localparam int N  = dese_pkg::STACK_DEPTH;
	localparam int DW = dese_pkg::DATA_W;
	localparam int CW = dese_pkg::CNT_W;
	localparam int IW = dese_pkg::IDX_W;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_EXEC   = 7'b0000010,
		S_MUL    = 7'b0000100,
		S_DIV    = 7'b0001000,
		S_PICKUP = 7'b0010000,
		S_PICKDN = 7'b0100000,
		S_REPORT = 7'b1000000
	} state_t;

	state_t               state_q;
	dese_pkg::item_t      item_q;
	logic [CW-1:0]        depth_q;
	logic                 err_q;
	logic [IW-1:0]        cnt_q;
	logic [DW-1:0]        tmp_q;
	logic [DW-1:0]        prod_q;
	logic [DW-1:0]        acc_q;
	logic [2:0]           mstep_q;
	logic                 result_valid_q;
	dese_pkg::result_t    result_q;

	dese_pkg::cell_ctrl_t ctrl;
	logic [DW-1:0]        stk [N];
	logic [DW-1:0]        a, b, alu;
	logic                 div_start, div_done;
	logic [DW-1:0]        div_quo, div_rem;
	logic [31:0]          ma, mb;

	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_cell
			dese_cell u_cell (
				.clk   (clk),
				.pos   (IW'(gi)),
				.ctrl  (ctrl),
				.above (stk[(gi + 1) % N]),
				.below (stk[(gi + N - 1) % N]),
				.data  (stk[gi])
			);
		end
	endgenerate

	dese_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (a),
		.divisor   (b),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign a = stk[1];
	assign b = stk[0];

	// combinational results of the binary operators other than mul, div and mod
	always_comb begin
		case (item_q.operation)
			dese_pkg::OP_ADD: alu = a + b;
			dese_pkg::OP_SUB: alu = a - b;
			dese_pkg::OP_AND: alu = a & b;
			dese_pkg::OP_OR:  alu = a | b;
			dese_pkg::OP_XOR: alu = a ^ b;
			dese_pkg::OP_SHL: alu = (b >= 64'd64) ? '0 : a << b[5:0];
			dese_pkg::OP_SHR: alu = (b >= 64'd64) ? '0 : a >> b[5:0];
			dese_pkg::OP_SAR: alu = (b >= 64'd64) ? {DW{a[DW-1]}}
			                                      : DW'($signed(a) >>> b[5:0]);
			dese_pkg::OP_GE:  alu = DW'(a >= b);
			dese_pkg::OP_LE:  alu = DW'(a <= b);
			dese_pkg::OP_GT:  alu = DW'(a > b);
			dese_pkg::OP_LT:  alu = DW'(a < b);
			dese_pkg::OP_EQ:  alu = DW'(a == b);
			default:          alu = DW'(a != b);
		endcase
	end

	// partial product operand select for the 32x32 multiplier
	always_comb begin
		case (mstep_q)
			3'd0:    begin ma = a[31:0];  mb = b[31:0];  end
			3'd1:    begin ma = a[31:0];  mb = b[63:32]; end
			default: begin ma = a[63:32]; mb = b[31:0];  end
		endcase
	end

	logic is_bin, is_pick_ok, full;
	assign is_bin = (item_q.operation >= dese_pkg::OP_ADD) &&
	                (item_q.operation <= dese_pkg::OP_NE) &&
	                (item_q.operation != dese_pkg::OP_NOT) &&
	                (item_q.operation != dese_pkg::OP_ABS);
	assign full = (depth_q >= CW'(N));
	assign is_pick_ok = ({1'b0, depth_q} > 8'(item_q.immediate));

	always_comb begin
		ctrl.mode = dese_pkg::CM_HOLD;
		ctrl.idx  = '0;
		ctrl.wr0  = 1'b0;
		ctrl.wval = '0;
		div_start = 1'b0;
		case (state_q)
			S_EXEC: begin
				case (item_q.operation)
					dese_pkg::OP_PUSH, dese_pkg::OP_PUSH_REG: begin
						if (!full) begin
							ctrl.mode = dese_pkg::CM_DOWN;
							ctrl.wval = item_q.value;
						end
					end
					dese_pkg::OP_NOT: begin
						ctrl.mode = dese_pkg::CM_WRTOP;
						ctrl.wval = ~b;
					end
					dese_pkg::OP_ABS: begin
						ctrl.mode = dese_pkg::CM_WRTOP;
						ctrl.wval = b[DW-1] ? (DW'(0) - b) : b;
					end
					dese_pkg::OP_ADDCONST: begin
						ctrl.mode = dese_pkg::CM_WRTOP;
						ctrl.wval = b + item_q.value;
					end
					dese_pkg::OP_DEREF: begin
						ctrl.mode = dese_pkg::CM_WRTOP;
						case (item_q.immediate)
							8'd1:    ctrl.wval = {56'd0, item_q.value[7:0]};
							8'd2:    ctrl.wval = {48'd0, item_q.value[15:0]};
							8'd4:    ctrl.wval = {32'd0, item_q.value[31:0]};
							8'd8:    ctrl.wval = item_q.value;
							default: ctrl.wval = '0;
						endcase
					end
					dese_pkg::OP_DROP: begin
						if (is_pick_ok) begin
							ctrl.mode = dese_pkg::CM_UP;
							ctrl.idx  = item_q.immediate[IW-1:0];
						end
					end
					dese_pkg::OP_MUL: ;
					dese_pkg::OP_DIV, dese_pkg::OP_MOD: begin
						div_start = (depth_q >= CW'(2)) && (b != '0);
					end
					default: begin
						if (is_bin && depth_q >= CW'(2)) begin
							ctrl.mode = dese_pkg::CM_UP;
							ctrl.idx  = IW'(1);
							ctrl.wr0  = 1'b1;
							ctrl.wval = alu;
						end
					end
				endcase
				// single-operand ops that rewrite the top leave an empty stack alone
				if (depth_q == '0 && ctrl.mode == dese_pkg::CM_WRTOP)
					ctrl.mode = dese_pkg::CM_HOLD;
			end
			S_MUL: begin
				if (mstep_q == 3'd4) begin
					ctrl.mode = dese_pkg::CM_UP;
					ctrl.idx  = IW'(1);
					ctrl.wr0  = 1'b1;
					ctrl.wval = acc_q;
				end
			end
			S_DIV: begin
				if (div_done) begin
					ctrl.mode = dese_pkg::CM_UP;
					ctrl.idx  = IW'(1);
					ctrl.wr0  = 1'b1;
					ctrl.wval = (item_q.operation == dese_pkg::OP_DIV) ? div_quo : div_rem;
				end
			end
			S_PICKUP: begin
				if (cnt_q != item_q.immediate[IW-1:0])
					ctrl.mode = dese_pkg::CM_UP;
			end
			S_PICKDN: begin
				ctrl.mode = dese_pkg::CM_DOWN;
				ctrl.wval = (cnt_q == item_q.immediate[IW-1:0]) ? tmp_q : stk[N-1];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			depth_q        <= '0;
			err_q          <= 1'b0;
			cnt_q          <= '0;
			mstep_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall && state_q != S_REPORT)
				result_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (item_valid)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					cnt_q   <= '0;
					mstep_q <= '0;
					case (item_q.operation)
						dese_pkg::OP_PUSH, dese_pkg::OP_PUSH_REG: begin
							state_q <= S_REPORT;
							if ((item_q.operation == dese_pkg::OP_PUSH_REG && !item_q.read_ok) ||
							    full)
								err_q <= 1'b1;
							if (!full)
								depth_q <= depth_q + 1'b1;
						end
						dese_pkg::OP_NOT, dese_pkg::OP_ABS, dese_pkg::OP_ADDCONST: begin
							state_q <= S_REPORT;
							if (depth_q == '0)
								err_q <= 1'b1;
						end
						dese_pkg::OP_DEREF: begin
							state_q <= S_REPORT;
							if (depth_q == '0)
								err_q <= 1'b1;
							else if (!item_q.read_ok ||
							         (item_q.immediate != 8'd1 && item_q.immediate != 8'd2 &&
							          item_q.immediate != 8'd4 && item_q.immediate != 8'd8))
								err_q <= 1'b1;
						end
						dese_pkg::OP_PICK: begin
							if (!is_pick_ok || full) begin
								err_q   <= 1'b1;
								state_q <= S_REPORT;
							end else begin
								state_q <= S_PICKUP;
							end
						end
						dese_pkg::OP_DROP: begin
							state_q <= S_REPORT;
							if (!is_pick_ok)
								err_q <= 1'b1;
							else
								depth_q <= depth_q - 1'b1;
						end
						dese_pkg::OP_CLEAR: begin
							state_q <= S_REPORT;
							depth_q <= '0;
							err_q   <= 1'b0;
						end
						default: begin
							if (!is_bin || depth_q < CW'(2) ||
							    ((item_q.operation == dese_pkg::OP_DIV ||
							      item_q.operation == dese_pkg::OP_MOD) && b == '0)) begin
								err_q   <= 1'b1;
								state_q <= S_REPORT;
							end else if (item_q.operation == dese_pkg::OP_MUL) begin
								state_q <= S_MUL;
							end else if (item_q.operation == dese_pkg::OP_DIV ||
							             item_q.operation == dese_pkg::OP_MOD) begin
								state_q <= S_DIV;
							end else begin
								depth_q <= depth_q - 1'b1;
								state_q <= S_REPORT;
							end
						end
					endcase
				end
				S_MUL: begin
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == 3'd4) begin
						depth_q <= depth_q - 1'b1;
						state_q <= S_REPORT;
					end
				end
				S_DIV: begin
					if (div_done) begin
						depth_q <= depth_q - 1'b1;
						state_q <= S_REPORT;
					end
				end
				S_PICKUP: begin
					if (cnt_q == item_q.immediate[IW-1:0]) begin
						cnt_q   <= '0;
						state_q <= S_PICKDN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_PICKDN: begin
					if (cnt_q == item_q.immediate[IW-1:0]) begin
						depth_q <= depth_q + 1'b1;
						state_q <= S_REPORT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_REPORT: begin
					if (!result_valid_q || !result_stall) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item_valid)
			item_q <= item;
		if (state_q == S_PICKUP && cnt_q == item_q.immediate[IW-1:0])
			tmp_q <= stk[0];
		if (state_q == S_MUL) begin
			prod_q <= DW'(ma) * DW'(mb);
			case (mstep_q)
				3'd1:    acc_q <= prod_q;
				3'd2,
				3'd3:    acc_q <= acc_q + {prod_q[31:0], 32'd0};
				default: acc_q <= acc_q;
			endcase
		end
		if (state_q == S_REPORT && (!result_valid_q || !result_stall)) begin
			result_q.top_value   <= (depth_q != '0) ? stk[0] : '0;
			result_q.stack_depth <= 7'(depth_q);
			result_q.error_flag  <= err_q;
		end
	end

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== rtl/core/dese_checker.sv =====
// dese_checker: port-level checks on the stack evaluator's channels
// depends on dese_pkg; bound to dwarf_expression_stack_evaluator
module dese_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_stall,
	input  dese_pkg::item_t     item,
	input  logic                result_valid,
	input  logic                result_stall,
	input  dese_pkg::result_t   result
);

	// one item in flight: after a transfer the input side is busy
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input taken while an item is in flight");

	// a stalled input item stays put until its transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("stalled input item changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.stack_depth <= 7'(dese_pkg::STACK_DEPTH))
		else $error("depth beyond stack size");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.stack_depth == '0 |-> result.top_value == '0)
		else $error("empty stack shows nonzero top");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

endmodule

bind dwarf_expression_stack_evaluator dese_checker u_dese_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
